>>> rtl/core/abef_pkg.sv
// ----------------------------------------------------------------------------
// abef_pkg: shared types, constants and microprogram
// Word formats, register indexes, control word layout and the control
// store for the band-limit / emphasis filter sequencer.
// ----------------------------------------------------------------------------
package abef_pkg;

  localparam int PASSES       = 8;
  localparam int MAX_CHANNELS = 2;

  localparam int ALPHA_W   = 25;
  localparam int ACC_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = 2;

  localparam int PASS_W  = (PASSES > 1) ? $clog2(PASSES) : 1;
  localparam int STG_DEPTH = 2 * PASSES * MAX_CHANNELS;
  localparam int STG_AW  = (STG_DEPTH > 1) ? $clog2(STG_DEPTH) : 1;
  localparam int EMPH_DEPTH = 2 * MAX_CHANNELS;
  localparam int EMPH_AW = (EMPH_DEPTH > 1) ? $clog2(EMPH_DEPTH) : 1;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 25'd16777216;
  localparam logic signed [ACC_W-1:0] ONE_Q28     = 32'sd268435456;
  localparam logic signed [ACC_W-1:0] NEG_ONE_Q28 = -32'sd268435456;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT = 3'd0,
    REG_LOWPASS_ALPHA = 3'd1,
    REG_HIGHPASS_ALPHA = 3'd2,
    REG_PRE_ALPHA     = 3'd3,
    REG_POST_ALPHA    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic               channel_index;
    logic signed [15:0] sample_in;
    logic               end_of_block;
  } in_word_t;

  typedef struct packed {
    logic               channel_tag;
    logic signed [15:0] sample_out;
    logic               last_in_block;
  } out_word_t;

  // Micro-operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_MUL,    // d = x - mem, product = d * alpha
    OP_ACC,    // y = sat(mem + product >> 24), write back
    OP_CLAMP,  // x = clamp(sat(x + aux), +-1.0)
    OP_OUT     // quantize x to 16 bits, hand to output register
  } uop_t;

  typedef enum logic [1:0] {COEF_LP, COEF_HP, COEF_PRE, COEF_POST} coef_t;
  typedef enum logic {BANK_STAGE, BANK_EMPH} bank_t;
  typedef enum logic [1:0] {RES_PASS, RES_HIGH, RES_AUX} res_t;
  typedef enum logic [1:0] {JMP_NONE, JMP_LOOP, JMP_IDLE_CH} cond_t;

  typedef logic [3:0] step_t;

  typedef struct packed {
    uop_t  op;
    coef_t coef;
    bank_t bank;
    logic  off;      // upper half of the channel's stage bank / de-emphasis slot
    res_t  res;
    cond_t cond;
    step_t target;
  } ctl_word_t;

  localparam step_t ST_ENTRY    = 4'd0;
  localparam step_t ST_LP_MUL   = 4'd1;
  localparam step_t ST_LP_ACC   = 4'd2;
  localparam step_t ST_HP_MUL   = 4'd3;
  localparam step_t ST_HP_ACC   = 4'd4;
  localparam step_t ST_PRE_MUL  = 4'd5;
  localparam step_t ST_PRE_ACC  = 4'd6;
  localparam step_t ST_CLAMP    = 4'd7;
  localparam step_t ST_POST_MUL = 4'd8;
  localparam step_t ST_POST_ACC = 4'd9;
  localparam step_t ST_OUT      = 4'd10;

  function automatic ctl_word_t ucode(step_t s);
    ctl_word_t w;
    w = '{op: OP_NOP, coef: COEF_LP, bank: BANK_STAGE, off: 1'b0,
          res: RES_PASS, cond: JMP_NONE, target: ST_ENTRY};
    case (s)
      ST_ENTRY: begin
        w.cond = JMP_IDLE_CH; w.target = ST_OUT;
      end
      ST_LP_MUL: begin
        w.op = OP_MUL; w.coef = COEF_LP;
      end
      ST_LP_ACC: begin
        w.op = OP_ACC; w.res = RES_PASS; w.cond = JMP_LOOP; w.target = ST_LP_MUL;
      end
      ST_HP_MUL: begin
        w.op = OP_MUL; w.coef = COEF_HP; w.off = 1'b1;
      end
      ST_HP_ACC: begin
        w.op = OP_ACC; w.off = 1'b1; w.res = RES_HIGH;
        w.cond = JMP_LOOP; w.target = ST_HP_MUL;
      end
      ST_PRE_MUL: begin
        w.op = OP_MUL; w.coef = COEF_PRE; w.bank = BANK_EMPH;
      end
      ST_PRE_ACC: begin
        w.op = OP_ACC; w.bank = BANK_EMPH; w.res = RES_AUX;
      end
      ST_CLAMP: begin
        w.op = OP_CLAMP;
      end
      ST_POST_MUL: begin
        w.op = OP_MUL; w.coef = COEF_POST; w.bank = BANK_EMPH; w.off = 1'b1;
      end
      ST_POST_ACC: begin
        w.op = OP_ACC; w.bank = BANK_EMPH; w.off = 1'b1; w.res = RES_PASS;
      end
      ST_OUT: begin
        w.op = OP_OUT;
      end
      default: begin
        w.op = OP_NOP;
      end
    endcase
    return w;
  endfunction

  localparam logic signed [35:0] SAT_HI = 36'sd2147483647;
  localparam logic signed [35:0] SAT_LO = -36'sd2147483648;

  function automatic logic signed [ACC_W-1:0] sat32(logic signed [35:0] v);
    if (v > SAT_HI) return 32'sh7fffffff;
    if (v < SAT_LO) return 32'sh80000000;
    return v[ACC_W-1:0];
  endfunction

endpackage

>>> rtl/core/audio_bandlimit_emphasis_filter.sv
// ----------------------------------------------------------------------------
// audio_bandlimit_emphasis_filter: cascaded one-pole band-limit and emphasis
// Microcoded sequencer over one shared multiply / accumulate datapath that
// runs each channel's lowpass, highpass, pre-emphasis and de-emphasis stages.
// ----------------------------------------------------------------------------
// Each accepted word runs the microprogram up to the output step; a sample on
//   a channel that is not in use skips to the output step (result 0).
// A new word is taken only after the current one is in the output register;
//   every filter stage takes two steps of the single multiplier (MUL then ACC).
// Reset (rst_n low, synchronous): configuration registers go to their defaults,
//   all filter memories clear in the same cycle, sequencer idle, no output pending.
module audio_bandlimit_emphasis_filter
  import abef_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // sample input
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  // filtered output
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ALPHA_W-1:0]   cfg_data
);

  // Configuration; coefficients are stored already limited to 1.0
  logic [CNT_W-1:0]   chan_count_r;
  logic [ALPHA_W-1:0] lp_alpha_r, hp_alpha_r, pre_alpha_r, post_alpha_r;
  logic [ALPHA_W-1:0] cfg_alpha_lim;

  // Filter memories (Q3.28)
  logic signed [ACC_W-1:0] stage_mem_r [STG_DEPTH];
  logic signed [ACC_W-1:0] emph_mem_r  [EMPH_DEPTH];

  // Sequencer
  logic                busy_r, busy_nxt;
  step_t               step_r, step_nxt;
  logic [PASS_W-1:0]   pass_r, pass_nxt;
  logic                active_r, active_nxt;
  logic                ch_r, ch_nxt;
  logic                eob_r, eob_nxt;
  ctl_word_t           ctl;

  // Datapath
  logic signed [ACC_W-1:0] x_r, x_nxt;
  logic signed [ACC_W-1:0] aux_r, aux_nxt;
  logic signed [ACC_W-1:0] memq_r, memq_nxt;
  logic signed [58:0]      prod_r, prod_nxt;

  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_data_r, out_data_nxt;

  logic [STG_AW-1:0]       stg_addr;
  logic [EMPH_AW-1:0]      emph_addr;
  logic signed [ACC_W-1:0] mem_rd;
  logic [ALPHA_W-1:0]      alpha_sel;
  logic signed [32:0]      diff;
  logic signed [ACC_W-1:0] y_val, hp_val, sum_sat, clamp_val;
  logic signed [15:0]      q_val;
  logic                    mem_we;

  assign in_ready  = !busy_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign ctl       = ucode(step_r);

  assign cfg_alpha_lim = (cfg_data > ALPHA_ONE) ? ALPHA_ONE : cfg_data;

  // Address of the current stage's memory word
  assign stg_addr  = STG_AW'(int'(ch_r) * 2 * PASSES + (ctl.off ? PASSES : 0) + int'(pass_r));
  assign emph_addr = EMPH_AW'(int'(ch_r) * 2 + int'(ctl.off));
  assign mem_rd    = (ctl.bank == BANK_STAGE) ? stage_mem_r[stg_addr] : emph_mem_r[emph_addr];

  always_comb begin
    case (ctl.coef)
      COEF_LP:   alpha_sel = lp_alpha_r;
      COEF_HP:   alpha_sel = hp_alpha_r;
      COEF_PRE:  alpha_sel = pre_alpha_r;
      COEF_POST: alpha_sel = post_alpha_r;
      default:   alpha_sel = lp_alpha_r;
    endcase
  end

  // MUL step: difference to the stored state, one multiply
  assign diff = 33'(x_r) - 33'(mem_rd);

  // ACC step: floor(product / 2^24) is an arithmetic shift
  assign y_val  = sat32(36'(memq_r) + 36'($signed(prod_r[58:24])));
  assign hp_val = sat32(36'(x_r) - 36'(y_val));

  // CLAMP step: pre-emphasis sum, limited to +-1.0
  assign sum_sat   = sat32(36'(x_r) + 36'(aux_r));
  assign clamp_val = (sum_sat > ONE_Q28) ? ONE_Q28 :
                     (sum_sat < NEG_ONE_Q28) ? NEG_ONE_Q28 : sum_sat;

  // OUT step: divide by 8192 toward zero, saturate to 16 bits
  always_comb begin
    logic [32:0]        mag;
    logic [19:0]        qm;
    logic signed [20:0] q;
    mag = x_r[ACC_W-1] ? 33'(-33'(x_r)) : 33'(x_r);
    qm  = mag[32:13];
    q   = x_r[ACC_W-1] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
    if (q > 21'sd32767)       q_val = 16'sh7fff;
    else if (q < -21'sd32768) q_val = 16'sh8000;
    else                      q_val = q[15:0];
  end

  assign mem_we = busy_r && (ctl.op == OP_ACC);

  // Sequencer and datapath next state
  always_comb begin
    int eff_count;
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    pass_nxt      = pass_r;
    active_nxt    = active_r;
    ch_nxt        = ch_r;
    eob_nxt       = eob_r;
    x_nxt         = x_r;
    aux_nxt       = aux_r;
    memq_nxt      = memq_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (chan_count_r == '0)                   eff_count = 1;
    else if (int'(chan_count_r) > MAX_CHANNELS) eff_count = MAX_CHANNELS;
    else                                       eff_count = int'(chan_count_r);

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    if (!busy_r) begin
      if (in_valid) begin
        busy_nxt   = 1'b1;
        step_nxt   = ST_ENTRY;
        pass_nxt   = '0;
        ch_nxt     = in_data.channel_index;
        eob_nxt    = in_data.end_of_block;
        active_nxt = int'(in_data.channel_index) < eff_count;
        x_nxt      = {{3{in_data.sample_in[15]}}, in_data.sample_in, 13'd0};
      end
    end else begin
      step_nxt = step_r + 4'd1;
      case (ctl.op)
        OP_MUL: begin
          memq_nxt = mem_rd;
          prod_nxt = diff * $signed({1'b0, alpha_sel});
        end
        OP_ACC: begin
          case (ctl.res)
            RES_PASS: x_nxt   = y_val;
            RES_HIGH: x_nxt   = hp_val;
            RES_AUX:  aux_nxt = hp_val;
            default:  x_nxt   = y_val;
          endcase
        end
        OP_CLAMP: x_nxt = clamp_val;
        OP_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{channel_tag: ch_r,
                              sample_out: active_r ? q_val : 16'sd0,
                              last_in_block: eob_r};
            busy_nxt      = 1'b0;
          end else begin
            step_nxt = step_r;  // hold until the output register frees up
          end
        end
        default: ;
      endcase

      case (ctl.cond)
        JMP_LOOP: begin
          if (int'(pass_r) == PASSES - 1) begin
            pass_nxt = '0;
          end else begin
            pass_nxt = pass_r + PASS_W'(1);
            step_nxt = ctl.target;
          end
        end
        JMP_IDLE_CH: begin
          if (!active_r) step_nxt = ctl.target;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      step_r       <= ST_ENTRY;
      pass_r       <= '0;
      out_valid_r  <= 1'b0;
      chan_count_r <= 2'd2;
      lp_alpha_r   <= 25'd12418986;
      hp_alpha_r   <= 25'd47671;
      pre_alpha_r  <= 25'd9857960;
      post_alpha_r <= 25'd9857960;
      for (int i = 0; i < STG_DEPTH; i++) stage_mem_r[i] <= '0;
      for (int i = 0; i < EMPH_DEPTH; i++) emph_mem_r[i] <= '0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_CHANNEL_COUNT:  chan_count_r <= cfg_data[CNT_W-1:0];
          REG_LOWPASS_ALPHA:  lp_alpha_r   <= cfg_alpha_lim;
          REG_HIGHPASS_ALPHA: hp_alpha_r   <= cfg_alpha_lim;
          REG_PRE_ALPHA:      pre_alpha_r  <= cfg_alpha_lim;
          REG_POST_ALPHA:     post_alpha_r <= cfg_alpha_lim;
          default: ;
        endcase
      end
      if (mem_we) begin
        if (ctl.bank == BANK_STAGE) stage_mem_r[stg_addr] <= y_val;
        else                        emph_mem_r[emph_addr] <= y_val;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    active_r   <= active_nxt;
    ch_r       <= ch_nxt;
    eob_r      <= eob_nxt;
    x_r        <= x_nxt;
    aux_r      <= aux_nxt;
    memq_r     <= memq_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (busy_r && step_r == ST_ENTRY))
    else $error("accepted word did not start the sequencer");

  a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && ctl.op == OP_CLAMP) |=> (x_r <= ONE_Q28 && x_r >= NEG_ONE_Q28))
    else $error("clamp step left value outside +-1.0");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy_r && ctl.op == OP_OUT))
    else $error("output word appeared without an output step");

  a_pass_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (pass_r == '0))
    else $error("pass counter not back at zero while idle");

endmodule
